FILE: rtl/pat_pkg.sv
package pat_pkg;

   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned CNT_W = $clog2(MAX_RESULTS);
   localparam logic [31:0] BROADCAST_ID = 32'hFFFF_FFFF;
   localparam logic [31:0] SETTLE_RESET = 32'd1500;
   localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
   localparam int unsigned CSR_IDX_W = 8;

   typedef enum logic [1:0] {
      MODE_REGISTER = 2'd0,
      MODE_ACK      = 2'd1,
      MODE_TICK     = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ACK_DIRECT  = 2'd0,
      ACK_RELAY   = 2'd1,
      ACK_TIMEOUT = 2'd2
   } ack_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETTLE  = 8'd0,
      CSR_TIMEOUT = 8'd1
   } csr_idx_type;

   // Command broadcast from the control logic to every cell.
   typedef struct packed {
      logic        alloc_en;
      logic        ack_en;
      logic        tick_en;
      logic        drain_en;
      logic        drain_stop;
      logic [31:0] packet_id;
      logic [31:0] node_id;
      logic [2:0]  channel;
      logic [31:0] now_ms;
      logic [31:0] settle_ms;
      logic [31:0] timeout_ms;
   } cmd_type;

   // Priority flags passed from each cell to the next higher one.
   typedef struct packed {
      logic taken;
      logic hit;
      logic pend;
   } chain_type;

   typedef struct packed {
      logic          pick;
      logic          pend;
      logic [31:0]   packet;
      logic [2:0]    channel;
      ack_state_type state;
   } cell_out_type;

endpackage

FILE: rtl/pat_cell.sv
module pat_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  pat_pkg::cmd_type     cmd,
   input  pat_pkg::chain_type   chain_in,
   output pat_pkg::chain_type   chain_out,
   output pat_pkg::cell_out_type status
);
   import pat_pkg::*;

   logic          valid_ff, valid_in;
   logic          pend_ff, pend_in;
   logic [31:0]   packet_ff, sent_ff, dest_ff;
   logic [2:0]    channel_ff;

   logic          is_bcast, match, alloc, hit, sel, expired;
   logic [31:0]   age, limit;
   ack_state_type ack_st, tick_st;

   always_comb begin
      is_bcast = (dest_ff == BROADCAST_ID);
      match    = valid_ff && (packet_ff == cmd.packet_id);
      alloc    = cmd.alloc_en && !valid_ff && !chain_in.taken;
      hit      = cmd.ack_en && match && !chain_in.hit;
      sel      = cmd.drain_en && pend_ff && !chain_in.pend;
      age      = cmd.now_ms - sent_ff;
      limit    = is_bcast ? cmd.settle_ms : cmd.timeout_ms;
      expired  = valid_ff && (age > limit);
      ack_st   = (is_bcast || (dest_ff != cmd.node_id)) ? ACK_RELAY : ACK_DIRECT;
      tick_st  = is_bcast ? ACK_RELAY : ACK_TIMEOUT;

      chain_out.taken = chain_in.taken || !valid_ff;
      chain_out.hit   = chain_in.hit || match;
      chain_out.pend  = chain_in.pend || pend_ff;

      status.pick    = hit || sel;
      status.pend    = pend_ff;
      status.packet  = packet_ff;
      status.channel = channel_ff;
      status.state   = hit ? ack_st : tick_st;

      valid_in = valid_ff;
      if (alloc) begin
         valid_in = 1'b1;
      end else if (hit || sel) begin
         valid_in = 1'b0;
      end

      pend_in = pend_ff;
      if (cmd.tick_en) begin
         pend_in = expired;
      end else if (sel || cmd.drain_stop) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         packet_ff  <= cmd.packet_id;
         dest_ff    <= cmd.node_id;
         channel_ff <= cmd.channel;
         sent_ff    <= cmd.now_ms;
      end
   end

endmodule

FILE: rtl/pending_ack_tracker.sv
// Pending acknowledgement tracker.
// Input channel (req_*): one transfer carries a mode (register, ack or tick),
// a packet id, a node id, a channel and the current millisecond time.
// Result channel (rsp_*): one transfer reports a resolved packet, its channel,
// how it was resolved, and rsp_last on the final result of an input item.
// Configuration channel (csr_*): index 0 sets the broadcast settle window,
// index 1 the direct ack timeout; csr_ready is always high.
// A register item gives no result. An ack item's result, if any, is shown in
// the cycle after acceptance. A tick compares every entry in parallel in its
// accept cycle and then drains the expired entries one per cycle while the
// receiver takes results, lowest slot first, at most 16 per tick. The single
// output register and the one-result-per-cycle drain across the cell row set
// the rate.
// req_ready is low while a tick is draining, and also while an unread result
// sits in the output register and the receiver does not take it; a stalled
// receiver therefore holds the result and stops the drain without loss.
// Reset clears all entries, the output register and restores both windows.
module pending_ack_tracker #(
   parameter int unsigned ENTRIES  = 16,
   parameter int unsigned CHANNELS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [31:0]                     req_packet_id,
   input  logic [31:0]                     req_node_id,
   input  logic [2:0]                      req_channel,
   input  logic [31:0]                     req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_packet_id_res,
   output logic [2:0]                      rsp_channel_res,
   output logic [1:0]                      rsp_ack_state,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata
);
   import pat_pkg::*;

   logic [31:0]      settle_ff, timeout_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_packet_ff, rsp_packet_in;
   logic [2:0]       rsp_channel_ff, rsp_channel_in;
   ack_state_type    rsp_state_ff, rsp_state_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0] count_ff, count_in;

   cmd_type          cmd;
   chain_type        chain [ENTRIES+1];
   cell_out_type     cell_out [ENTRIES];

   logic             req_fire, out_free, draining, any_pick, others_pend;
   logic [31:0]      pick_packet;
   logic [2:0]       pick_channel;
   logic [1:0]       pick_state;

   assign csr_ready = 1'b1;

   // Configuration registers; writes to unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff  <= SETTLE_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_SETTLE) begin
            settle_ff <= csr_wdata;
         end
         if (csr_index == CSR_TIMEOUT) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   // Gather the picked cell's fields and the pending summary from the row.
   // At most one cell picks in any cycle.
   always_comb begin
      any_pick     = 1'b0;
      others_pend  = 1'b0;
      draining     = 1'b0;
      pick_packet  = '0;
      pick_channel = '0;
      pick_state   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         draining    = draining | cell_out[i].pend;
         others_pend = others_pend | (cell_out[i].pend & ~cell_out[i].pick);
         any_pick    = any_pick | cell_out[i].pick;
         pick_packet  = pick_packet  | ({32{cell_out[i].pick}} & cell_out[i].packet);
         pick_channel = pick_channel | ({3{cell_out[i].pick}} & cell_out[i].channel);
         pick_state   = pick_state   | ({2{cell_out[i].pick}} & 2'(cell_out[i].state));
      end
   end

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = !draining && out_free;
      req_fire  = req_valid && req_ready;

      cmd.alloc_en   = req_fire && (req_mode == MODE_REGISTER) &&
                       (5'(req_channel) < 5'(CHANNELS));
      cmd.ack_en     = req_fire && (req_mode == MODE_ACK);
      cmd.tick_en    = req_fire && (req_mode == MODE_TICK);
      cmd.drain_en   = draining && out_free;
      // The sixteenth report of a tick ends the drain; the rest stay valid.
      cmd.drain_stop = cmd.drain_en && (count_ff == CNT_W'(MAX_RESULTS - 1));
      cmd.packet_id  = req_packet_id;
      cmd.node_id    = req_node_id;
      cmd.channel    = req_channel;
      cmd.now_ms     = req_now_ms;
      cmd.settle_ms  = settle_ff;
      cmd.timeout_ms = timeout_ff;

      count_in = count_ff;
      if (cmd.tick_en) begin
         count_in = '0;
      end else if (cmd.drain_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   assign chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      pat_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .status    (cell_out[g])
      );
   end

   // Output register: loaded by an ack hit or a drain step, held while stalled.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_packet_in  = rsp_packet_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_state_in   = rsp_state_ff;
      rsp_last_in    = rsp_last_ff;
      if (any_pick) begin
         rsp_valid_in   = 1'b1;
         rsp_packet_in  = pick_packet;
         rsp_channel_in = pick_channel;
         rsp_state_in   = ack_state_type'(pick_state);
         rsp_last_in    = cmd.ack_en || cmd.drain_stop || !others_pend;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_packet_ff  <= rsp_packet_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_id_res = rsp_packet_ff;
   assign rsp_channel_res   = rsp_channel_ff;
   assign rsp_ack_state     = 2'(rsp_state_ff);
   assign rsp_last          = rsp_last_ff;

endmodule

FILE: rtl/pat_checker.sv
module pat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_packet_id_res,
   input logic [1:0]  rsp_ack_state,
   input logic        rsp_last
);
   import pat_pkg::*;

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_id_res))
      else $error("result changed while stalled");

   // Reset leaves the output register empty.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A register item never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_REGISTER) |=> !rsp_valid)
      else $error("register item produced a result");

   // A direct acknowledgement only comes from an ack item, which has one result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ack_state == ACK_DIRECT) |-> rsp_last)
      else $error("direct ack without last");

endmodule

bind pending_ack_tracker pat_checker u_pat_checker (.*);
